// File: hw/rtl/sor_pkg.sv
// Shared types, widths and codes for the segment occupancy rasterizer.
package sor_pkg;

  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int CELL_W     = 16;
  localparam int GRID_W     = 9;
  localparam int ROWSEL_W   = 8;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QUO_W      = 26;
  localparam int SUM_W      = 2 * MAG_W + 1;
  localparam int RAD_W      = SUM_W + 3;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS    = 256;
  localparam int DEF_MAX_SAMPLES = 1024;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd4;

  localparam logic [CELL_W-1:0] RST_CELL_SIZE = 16'd256;
  localparam logic [GRID_W-1:0] RST_GRID_DIM  = 9'd256;

  typedef enum logic [1:0] {CMD_CLEAR, CMD_MARK, CMD_READ, CMD_SKIP} cmd_kind_t;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [ROWSEL_W-1:0]       cell_row;
    logic [ROWSEL_W-1:0]       cell_column;
  } req_t;

  typedef struct packed {
    logic               occupied;
    logic [COUNT_W-1:0] sample_count;
    logic               capped;
  } rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [CELL_W-1:0]         cell_size;
    logic [GRID_W-1:0]         grid_columns;
    logic [GRID_W-1:0]         grid_rows;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [ROWSEL_W-1:0]       cell_row;
    logic [ROWSEL_W-1:0]       cell_column;
  } cmd_t;

endpackage

// File: hw/rtl/sor_ifs.sv
// Request and result channel interfaces.
interface sor_req_if;
  logic          valid;
  logic          ready;
  sor_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sor_rsp_if;
  logic          valid;
  logic          ready;
  sor_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/sor_ram.sv
// Generic simple dual-port RAM with registered read.
module sor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/sor_divu.sv
// Unsigned restoring divider, one quotient bit per cycle.
module sor_divu #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(NUM_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], ge};
        rem_r <= rem_nxt;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

// File: hw/rtl/sor_isqrt.sv
// Digit-by-digit square root, rounded up, two radicand bits per cycle.
module sor_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sor_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [sor_pkg::ROOT_W-1:0] root
);
  import sor_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    rem_sub = rem_sh - trial;
    ge      = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(ROOT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], ge};
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // round up when a remainder is left
  assign root = root_r + ROOT_W'(rem_r != '0);
  assign done = done_r;
endmodule

// File: hw/rtl/sor_front.sv
// Request intake: classifies each request and holds it in a two-entry queue.
module sor_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          init_busy,
  sor_req_if.sink       in_chan,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output sor_pkg::cmd_t cmd
);
  import sor_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;
  cmd_t             cls;

  always_comb begin
    cls.start_x     = in_chan.payload.start_x;
    cls.start_y     = in_chan.payload.start_y;
    cls.dx          = {in_chan.payload.end_x[COORD_W-1], in_chan.payload.end_x}
                      - {in_chan.payload.start_x[COORD_W-1], in_chan.payload.start_x};
    cls.dy          = {in_chan.payload.end_y[COORD_W-1], in_chan.payload.end_y}
                      - {in_chan.payload.start_y[COORD_W-1], in_chan.payload.start_y};
    cls.cell_row    = in_chan.payload.cell_row;
    cls.cell_column = in_chan.payload.cell_column;
    unique case (in_chan.payload.op)
      OP_CLEAR: cls.kind = CMD_CLEAR;
      OP_MARK:  cls.kind = CMD_MARK;
      OP_READ:  cls.kind = CMD_READ;
      OP_NONE:  cls.kind = CMD_SKIP;
    endcase
  end

  assign in_chan.ready = (count_r != CNT_W'(QUEUE_DEPTH)) && !init_busy;
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = count_r != '0;
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= cls;
        wr_ptr_r      <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

// File: hw/rtl/sor_back.sv
// Execution engine: grid clears, cell reads and segment sampling into the grid RAM.
module sor_back #(
  parameter int MAX_COLUMNS = sor_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = sor_pkg::DEF_MAX_ROWS,
  parameter int MAX_SAMPLES = sor_pkg::DEF_MAX_SAMPLES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sor_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sor_pkg::cmd_t cmd,
  output logic          init_busy,
  sor_rsp_if.source     out_chan
);
  import sor_pkg::*;

  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int DDW = NW + CELL_W;
  localparam int DNW = (MAG_W + NW > ROOT_W + 1) ? MAG_W + NW : ROOT_W + 1;
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [4:0] {
    B_INIT, B_IDLE, B_CLR, B_RD_REQ, B_RD_WAIT, B_SQX, B_SQY, B_SQRT, B_NDIV,
    B_MUL_DEN, B_MUL_BX, B_MUL_BY, B_DIV_BX, B_DIV_BY, B_DIV_DX, B_DIV_DY,
    B_WALK_RD, B_WALK_WR, B_DONE
  } state_t;

  state_t                   state_r;
  logic                     unit_run_r;
  logic [RAW-1:0]           clr_r;
  logic                     out_valid_r;
  rsp_t                     out_data_r;
  rsp_t                     rsp_r;
  cmd_t                     cmd_r;
  logic [CELL_W-1:0]        cell_r;
  logic [2*MAG_W-1:0]       sq_r;
  logic [SUM_W-1:0]         sum_r;
  logic [ROOT_W-1:0]        root_r;
  logic [NW-1:0]            n_r;
  logic                     cap_r;
  logic [DDW-1:0]           den_r;
  logic [DNW-1:0]           bx_mag_r;
  logic [DNW-1:0]           by_mag_r;
  logic                     bx_neg_r;
  logic                     by_neg_r;
  logic signed [QUO_W-1:0]  qc_r, qr_r, dqc_r, dqr_r;
  logic [DDW-1:0]           rc_r, rr_r, drc_r, drr_r;
  logic [NW-1:0]            s_r;

  logic signed [DIFF_W-1:0] dx_n, dy_n, xo, yo, xo_n, yo_n;
  logic [MAG_W-1:0]         dx_mag, dy_mag, xo_mag, yo_mag;
  logic [2*MAG_W-1:0]       dx_sq, dy_sq;
  logic [QUO_W-1:0]         cols_lim, rows_lim;
  logic                     in_grid;
  logic [RAW-1:0]           row_idx;
  logic [CAW-1:0]           col_idx;
  logic [RAW+ROWSEL_W-1:0]  rd_row_ext;
  logic [CAW+ROWSEL_W-1:0]  rd_col_ext;
  logic                     rd_in_range;
  logic [DDW:0]             rc_sum, rr_sum;
  logic                     c_wrap, r_wrap;
  logic [DDW-1:0]           rc_nxt, rr_nxt;
  logic signed [QUO_W-1:0]  qc_nxt, qr_nxt;
  logic [NW+COUNT_W-1:0]    n_ext;
  logic                     last_sample;

  logic                     div_start, sq_start, div_done, sq_done, div_neg;
  logic [DNW-1:0]           div_num, div_quo;
  logic [DDW-1:0]           div_den, div_rem;
  logic [QUO_W-1:0]         q_mag;
  logic signed [QUO_W-1:0]  fq;
  logic [DDW-1:0]           fr;
  logic [ROOT_W-1:0]        sq_root;

  logic                     ram_we;
  logic [RAW-1:0]           ram_waddr, ram_raddr;
  logic [MAX_COLUMNS-1:0]   ram_wdata, ram_rdata;

  always_comb begin
    dx_n   = -cmd_r.dx;
    dy_n   = -cmd_r.dy;
    dx_mag = cmd_r.dx[DIFF_W-1] ? dx_n[MAG_W-1:0] : cmd_r.dx[MAG_W-1:0];
    dy_mag = cmd_r.dy[DIFF_W-1] ? dy_n[MAG_W-1:0] : cmd_r.dy[MAG_W-1:0];
    dx_sq  = dx_mag * dx_mag;
    dy_sq  = dy_mag * dy_mag;
    xo     = {cmd_r.start_x[COORD_W-1], cmd_r.start_x} - {cfg.origin_x[COORD_W-1], cfg.origin_x};
    yo     = {cmd_r.start_y[COORD_W-1], cmd_r.start_y} - {cfg.origin_y[COORD_W-1], cfg.origin_y};
    xo_n   = -xo;
    yo_n   = -yo;
    xo_mag = xo[DIFF_W-1] ? xo_n[MAG_W-1:0] : xo[MAG_W-1:0];
    yo_mag = yo[DIFF_W-1] ? yo_n[MAG_W-1:0] : yo[MAG_W-1:0];

    cols_lim = ({{(QUO_W-GRID_W){1'b0}}, cfg.grid_columns} > QUO_W'(MAX_COLUMNS))
               ? QUO_W'(MAX_COLUMNS) : {{(QUO_W-GRID_W){1'b0}}, cfg.grid_columns};
    rows_lim = ({{(QUO_W-GRID_W){1'b0}}, cfg.grid_rows} > QUO_W'(MAX_ROWS))
               ? QUO_W'(MAX_ROWS) : {{(QUO_W-GRID_W){1'b0}}, cfg.grid_rows};
    in_grid  = !qc_r[QUO_W-1] && ($unsigned(qc_r) < cols_lim)
               && !qr_r[QUO_W-1] && ($unsigned(qr_r) < rows_lim);
    row_idx  = qr_r[RAW-1:0];
    col_idx  = qc_r[CAW-1:0];

    rd_row_ext  = {{RAW{1'b0}}, cmd_r.cell_row};
    rd_col_ext  = {{CAW{1'b0}}, cmd_r.cell_column};
    rd_in_range = ({{(QUO_W-ROWSEL_W){1'b0}}, cmd_r.cell_row} < rows_lim)
                  && ({{(QUO_W-ROWSEL_W){1'b0}}, cmd_r.cell_column} < cols_lim);

    // incremental floor division: add the per-step quotient and remainder
    rc_sum = {1'b0, rc_r} + {1'b0, drc_r};
    rr_sum = {1'b0, rr_r} + {1'b0, drr_r};
    c_wrap = rc_sum >= {1'b0, den_r};
    r_wrap = rr_sum >= {1'b0, den_r};
    rc_nxt = c_wrap ? DDW'(rc_sum - {1'b0, den_r}) : rc_sum[DDW-1:0];
    rr_nxt = r_wrap ? DDW'(rr_sum - {1'b0, den_r}) : rr_sum[DDW-1:0];
    qc_nxt = qc_r + dqc_r + QUO_W'(c_wrap);
    qr_nxt = qr_r + dqr_r + QUO_W'(r_wrap);
    n_ext  = {{COUNT_W{1'b0}}, n_r};
    last_sample = s_r == n_r;

    div_num = bx_mag_r;
    div_den = den_r;
    div_neg = 1'b0;
    case (state_r)
      B_NDIV: begin
        div_num = DNW'({1'b0, root_r} + {{(ROOT_W+1-CELL_W){1'b0}}, cell_r} - 1'b1);
        div_den = DDW'(cell_r);
      end
      B_DIV_BX: div_neg = bx_neg_r;
      B_DIV_BY: begin
        div_num = by_mag_r;
        div_neg = by_neg_r;
      end
      B_DIV_DX: begin
        div_num = DNW'(dx_mag);
        div_neg = cmd_r.dx[DIFF_W-1];
      end
      B_DIV_DY: begin
        div_num = DNW'(dy_mag);
        div_neg = cmd_r.dy[DIFF_W-1];
      end
      default: div_neg = 1'b0;
    endcase

    // signed floor from the unsigned result; remainder kept in [0, den)
    q_mag = div_quo[QUO_W-1:0];
    if (!div_neg) begin
      fq = q_mag;
      fr = div_rem;
    end else if (div_rem == '0) begin
      fq = -q_mag;
      fr = '0;
    end else begin
      fq = ~q_mag;
      fr = div_den - div_rem;
    end

    div_start = !unit_run_r && (state_r == B_NDIV || state_r == B_DIV_BX ||
                state_r == B_DIV_BY || state_r == B_DIV_DX || state_r == B_DIV_DY);
    sq_start  = !unit_run_r && (state_r == B_SQRT);

    ram_we    = (state_r == B_INIT) || (state_r == B_CLR) || (state_r == B_WALK_WR);
    ram_waddr = (state_r == B_WALK_WR) ? row_idx : clr_r;
    ram_wdata = (state_r == B_WALK_WR) ? (ram_rdata | (MAX_COLUMNS'(1) << col_idx)) : '0;
    ram_raddr = (state_r == B_RD_REQ) ? rd_row_ext[RAW-1:0] : row_idx;
  end

  sor_divu #(.NUM_W(DNW), .DEN_W(DDW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  sor_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand({1'b0, sum_r, 2'b00}), .done(sq_done), .root(sq_root)
  );

  sor_ram #(.WIDTH(MAX_COLUMNS), .DEPTH(MAX_ROWS)) u_grid (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      clr_r       <= '0;
      unit_run_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != B_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_INIT, B_CLR: begin
          if (clr_r == RAW'(MAX_ROWS - 1)) begin
            clr_r   <= '0;
            state_r <= (state_r == B_INIT) ? B_IDLE : B_DONE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        B_IDLE: begin
          if (cmd_valid) begin
            cmd_r  <= cmd;
            rsp_r  <= '0;
            cell_r <= (cfg.cell_size == '0) ? CELL_W'(1) : cfg.cell_size;
            unique case (cmd.kind)
              CMD_CLEAR: state_r <= B_CLR;
              CMD_MARK:  state_r <= B_SQX;
              CMD_READ:  state_r <= B_RD_REQ;
              CMD_SKIP:  state_r <= B_DONE;
            endcase
          end
        end
        B_RD_REQ: state_r <= B_RD_WAIT;
        B_RD_WAIT: begin
          rsp_r.occupied <= rd_in_range && ram_rdata[rd_col_ext[CAW-1:0]];
          state_r        <= B_DONE;
        end
        B_SQX: begin
          sq_r    <= dx_sq;
          state_r <= B_SQY;
        end
        B_SQY: begin
          sum_r   <= {1'b0, sq_r} + {1'b0, dy_sq};
          state_r <= B_SQRT;
        end
        B_SQRT: begin
          if (!unit_run_r) begin
            unit_run_r <= 1'b1;
          end else if (sq_done) begin
            unit_run_r <= 1'b0;
            root_r     <= sq_root;
            state_r    <= B_NDIV;
          end
        end
        B_NDIV: begin
          if (!unit_run_r) begin
            unit_run_r <= 1'b1;
          end else if (div_done) begin
            unit_run_r <= 1'b0;
            if (div_quo == '0) begin
              n_r   <= NW'(1);
              cap_r <= 1'b0;
            end else if (div_quo > DNW'(MAX_SAMPLES)) begin
              n_r   <= NW'(MAX_SAMPLES);
              cap_r <= 1'b1;
            end else begin
              n_r   <= div_quo[NW-1:0];
              cap_r <= 1'b0;
            end
            state_r <= B_MUL_DEN;
          end
        end
        B_MUL_DEN: begin
          den_r   <= n_r * cell_r;
          state_r <= B_MUL_BX;
        end
        B_MUL_BX: begin
          bx_mag_r <= xo_mag * n_r;
          bx_neg_r <= xo[DIFF_W-1];
          state_r  <= B_MUL_BY;
        end
        B_MUL_BY: begin
          by_mag_r <= yo_mag * n_r;
          by_neg_r <= yo[DIFF_W-1];
          state_r  <= B_DIV_BX;
        end
        B_DIV_BX, B_DIV_BY, B_DIV_DX, B_DIV_DY: begin
          if (!unit_run_r) begin
            unit_run_r <= 1'b1;
          end else if (div_done) begin
            unit_run_r <= 1'b0;
            unique case (state_r)
              B_DIV_BX: begin
                qc_r    <= fq;
                rc_r    <= fr;
                state_r <= B_DIV_BY;
              end
              B_DIV_BY: begin
                qr_r    <= fq;
                rr_r    <= fr;
                state_r <= B_DIV_DX;
              end
              B_DIV_DX: begin
                dqc_r   <= fq;
                drc_r   <= fr;
                state_r <= B_DIV_DY;
              end
              default: begin
                dqr_r   <= fq;
                drr_r   <= fr;
                s_r     <= '0;
                state_r <= B_WALK_RD;
              end
            endcase
          end
        end
        B_WALK_RD, B_WALK_WR: begin
          if (state_r == B_WALK_RD && in_grid) begin
            state_r <= B_WALK_WR;
          end else if (last_sample) begin
            rsp_r.sample_count <= n_ext[COUNT_W-1:0];
            rsp_r.capped       <= cap_r;
            state_r            <= B_DONE;
          end else begin
            s_r     <= s_r + 1'b1;
            qc_r    <= qc_nxt;
            qr_r    <= qr_nxt;
            rc_r    <= rc_nxt;
            rr_r    <= rr_nxt;
            state_r <= B_WALK_RD;
          end
        end
        B_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= rsp_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign cmd_ready        = state_r == B_IDLE;
  assign init_busy        = state_r == B_INIT;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_WALK_RD |-> (rc_r < den_r) && (rr_r < den_r))
    else $error("walk remainder not below divisor");

  a_sample_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_WALK_RD |-> (n_r != '0) && (s_r <= n_r))
    else $error("sample index out of range");

  a_write_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_WALK_WR |-> in_grid && $past(state_r) == B_WALK_RD)
    else $error("grid write outside the active area");

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready |-> !unit_run_r)
    else $error("request taken while a unit is running");
endmodule

// File: hw/rtl/segment_occupancy_rasterizer_top.sv
// Top level of the segment occupancy rasterizer: config registers, front and back.
//
// Keeps a MAX_ROWS x MAX_COLUMNS occupancy bit grid in a row-wide RAM. After
// reset the grid is swept clear, one row per cycle, and no request is taken
// until that ends; a clear request runs the same sweep. A cell read addresses
// its row and picks the bit from the registered read data. A mark request runs
// a square root and five passes through one shared bit-serial divider, then
// walks its n + 1 samples: a sample off the grid takes only the read state, one
// on the grid a read and a write state for the read-modify-write of a grid row.
// A two-entry request queue lets new requests arrive while one is worked on,
// and a result register holds a finished result until it is taken.
module segment_occupancy_rasterizer_top #(
  parameter int MAX_COLUMNS = sor_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = sor_pkg::DEF_MAX_ROWS,
  parameter int MAX_SAMPLES = sor_pkg::DEF_MAX_SAMPLES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [sor_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sor_pkg::CFG_DATA_W-1:0]  cfg_data,
  sor_req_if.sink                         in_chan,
  sor_rsp_if.source                       out_chan
);
  import sor_pkg::*;

  cfg_t cfg_r;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic init_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.cell_size    <= RST_CELL_SIZE;
      cfg_r.grid_columns <= RST_GRID_DIM;
      cfg_r.grid_rows    <= RST_GRID_DIM;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:     cfg_r.origin_x     <= cfg_data;
        CFG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_data;
        CFG_CELL_SIZE:    cfg_r.cell_size    <= cfg_data[CELL_W-1:0];
        CFG_GRID_COLUMNS: cfg_r.grid_columns <= cfg_data[GRID_W-1:0];
        CFG_GRID_ROWS:    cfg_r.grid_rows    <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  sor_front u_front (
    .clk(clk), .rst_n(rst_n), .init_busy(init_busy), .in_chan(in_chan),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  sor_back #(
    .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready), .cmd(cmd), .init_busy(init_busy), .out_chan(out_chan)
  );
endmodule
